/* rtl/cabfs_pkg.sv */
package cabfs_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_BLIT  = 2'd2,
    FUNC_NOP   = 2'd3
  } cabfs_func_e;

  typedef enum logic [2:0] {
    REG_DEST_WIDTH  = 3'd0,
    REG_DEST_HEIGHT = 3'd1,
    REG_X_OFFSET    = 3'd2,
    REG_Y_OFFSET    = 3'd3,
    REG_BLEND_MODE  = 3'd4
  } cabfs_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] pixel;
  } cabfs_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        changed;
    logic        clipped;
  } cabfs_out_t;

  typedef struct packed {
    logic [9:0]         dest_width;
    logic [9:0]         dest_height;
    logic signed [12:0] x_offset;
    logic signed [12:0] y_offset;
    logic               blend_mode;
  } cabfs_cfg_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        mrg;
    logic        clip;
    logic [31:0] pixel;
  } cabfs_op_t;

  // floor(v / 255) for v up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

/* rtl/cabfs_ram.sv */
module cabfs_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cabfs_front.sv */
module cabfs_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int AddrW      = 18
) (
  input  cabfs_pkg::cabfs_in_t  in_i,
  input  cabfs_pkg::cabfs_cfg_t cfg_i,
  output cabfs_pkg::cabfs_op_t  op_o,
  output logic [AddrW-1:0]      addr_o
);
  import cabfs_pkg::*;

  localparam logic [12:0]      MaxW   = 13'(MAX_WIDTH);
  localparam logic [12:0]      MaxH   = 13'(MAX_HEIGHT);
  localparam logic [AddrW-1:0] StrideC = AddrW'(MAX_WIDTH);

  logic               is_blit;
  logic signed [13:0] tx, ty;
  logic [12:0]        use_w, use_h;
  logic               in_area;
  logic [7:0]         sa;
  logic               known;

  always_comb begin
    is_blit = (in_i.func == FUNC_BLIT);
    known   = (in_i.func != FUNC_NOP);
    tx = $signed({2'b00, in_i.pos_x})
       + (is_blit ? $signed({cfg_i.x_offset[12], cfg_i.x_offset}) : 14'sd0);
    ty = $signed({2'b00, in_i.pos_y})
       + (is_blit ? $signed({cfg_i.y_offset[12], cfg_i.y_offset}) : 14'sd0);
    use_w = ({3'b000, cfg_i.dest_width} < MaxW) ? {3'b000, cfg_i.dest_width} : MaxW;
    use_h = ({3'b000, cfg_i.dest_height} < MaxH) ? {3'b000, cfg_i.dest_height} : MaxH;
    in_area = !tx[13] && !ty[13] && (tx[12:0] < use_w) && (ty[12:0] < use_h);
    sa = in_i.pixel[31:24];

    op_o.pixel = in_i.pixel;
    op_o.clip  = known && !in_area;
    op_o.rd    = in_area && (in_i.func == FUNC_READ);
    op_o.wr    = in_area && ((in_i.func == FUNC_WRITE) ||
                 (is_blit && (!cfg_i.blend_mode || (sa != 8'd0))));
    op_o.mrg   = in_area && is_blit && cfg_i.blend_mode &&
                 (sa != 8'd0) && (sa != 8'd255);

    addr_o = AddrW'(ty[11:0]) * StrideC + AddrW'(tx[11:0]);
  end

endmodule

/* rtl/cabfs_mix.sv */
module cabfs_mix (
  input  logic        clk_i,
  input  logic [31:0] dst_i,
  input  logic [31:0] src_i,
  output logic [31:0] mix_o
);
  import cabfs_pkg::*;

  logic [7:0]  sa, nsa, nda;
  logic [15:0] pa_d, pa_q;
  logic [15:0] ch_d [3];
  logic [15:0] ch_q [3];

  always_comb begin
    sa   = src_i[31:24];
    nsa  = 8'd255 - sa;
    nda  = 8'd255 - dst_i[31:24];
    pa_d = 16'(nda) * 16'(nsa);
    for (int c = 0; c < 3; c++) begin
      ch_d[c] = 16'(dst_i[8*c +: 8]) * 16'(nsa) + 16'(src_i[8*c +: 8]) * 16'(sa);
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;
    for (int c = 0; c < 3; c++) begin
      ch_q[c] <= ch_d[c];
    end
  end

  assign mix_o = {8'd255 - div255(pa_q), div255(ch_q[2]), div255(ch_q[1]),
                  div255(ch_q[0])};

endmodule

/* rtl/clipped_alpha_blit_frame_store_top.sv */
// An accepted word passes the s1 and s2 stage registers, and the output register after them gives its result strobe.
// Throughput: one word per cycle; busy_o stays low, the frame store read-modify-write
//   forwards pending writes so back-to-back words to the same pixel stay exact.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset clears control state and the registers to 512, 512, 0, 0, copy mode;
//   frame store contents are undefined until written, with no clearing pass.
module clipped_alpha_blit_frame_store_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  cabfs_pkg::cabfs_in_t              in_i,
  output logic                              done_o,
  output cabfs_pkg::cabfs_out_t             out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cabfs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cabfs_pkg::CfgDataW-1:0]    cfg_data_i
);
  import cabfs_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  cabfs_cfg_t cfg_q;
  cabfs_op_t  fr_op;
  logic [AddrW-1:0] fr_addr;
  logic       accept;

  logic             s1_valid_q;
  cabfs_op_t        s1_op_q;
  logic [AddrW-1:0] s1_addr_q;

  logic             s2_valid_q;
  cabfs_op_t        s2_op_q;
  logic [AddrW-1:0] s2_addr_q;
  logic [31:0]      s2_rdata_q;

  logic             wb_valid_q;
  logic [AddrW-1:0] wb_addr_q;
  logic [31:0]      wb_data_q;

  logic             done_q;
  cabfs_out_t       out_q;

  logic [31:0] ram_rdata, dst_fwd, mix_px, wdata;
  logic        ram_we;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width  <= 10'd512;
      cfg_q.dest_height <= 10'd512;
      cfg_q.x_offset    <= 13'sd0;
      cfg_q.y_offset    <= 13'sd0;
      cfg_q.blend_mode  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cabfs_reg_e'(cfg_index_i))
        REG_DEST_WIDTH:  cfg_q.dest_width  <= cfg_data_i[9:0];
        REG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data_i[9:0];
        REG_X_OFFSET:    cfg_q.x_offset    <= $signed(cfg_data_i[12:0]);
        REG_Y_OFFSET:    cfg_q.y_offset    <= $signed(cfg_data_i[12:0]);
        REG_BLEND_MODE:  cfg_q.blend_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cabfs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AddrW     (AddrW)
  ) u_front (
    .in_i  (in_i),
    .cfg_i (cfg_q),
    .op_o  (fr_op),
    .addr_o(fr_addr)
  );

  cabfs_ram #(
    .Width(32),
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s2_addr_q),
    .wdata_i(wdata),
    .raddr_i(fr_addr),
    .rdata_o(ram_rdata)
  );

  // forward the newest pending write to the same pixel
  always_comb begin
    if (s2_valid_q && s2_op_q.wr && (s2_addr_q == s1_addr_q)) begin
      dst_fwd = wdata;
    end else if (wb_valid_q && (wb_addr_q == s1_addr_q)) begin
      dst_fwd = wb_data_q;
    end else begin
      dst_fwd = ram_rdata;
    end
  end

  cabfs_mix u_mix (
    .clk_i(clk_i),
    .dst_i(dst_fwd),
    .src_i(s1_op_q.pixel),
    .mix_o(mix_px)
  );

  assign wdata  = s2_op_q.mrg ? mix_px : s2_op_q.pixel;
  assign ram_we = s2_valid_q && s2_op_q.wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      wb_valid_q <= ram_we;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q    <= fr_op;
    s1_addr_q  <= fr_addr;
    s2_op_q    <= s1_op_q;
    s2_addr_q  <= s1_addr_q;
    s2_rdata_q <= dst_fwd;
    wb_addr_q  <= s2_addr_q;
    wb_data_q  <= wdata;
    out_q.read_value <= s2_op_q.rd ? s2_rdata_q : 32'd0;
    out_q.changed    <= s2_op_q.wr;
    out_q.clipped    <= s2_op_q.clip;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted word gave no result");

  a_change_wrote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.changed) |-> $past(ram_we))
    else $error("changed reported without a frame store write");

  a_clip_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(out_o.clipped && (out_o.changed || (out_o.read_value != 32'd0))))
    else $error("clipped word touched the frame store");

  a_write_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(s1_valid_q))
    else $error("frame store write without a staged word");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import cabfs_pkg::*;

  localparam int MaxW        = 512;
  localparam int MaxH        = 512;
  localparam int Latency     = 3;
  localparam int LimitCycles = 200000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  cabfs_in_t             in_i;
  logic                  done_o;
  cabfs_out_t            out_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  clipped_alpha_blit_frame_store_top #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  typedef struct {
    bit          is_cfg;
    cabfs_reg_e  reg_idx;
    logic [12:0] reg_val;
    cabfs_in_t   word;
    bit          typed;
    cabfs_out_t  want;
  } plan_row_t;

  plan_row_t   plan[$];
  cabfs_out_t  pending_results[$];
  cabfs_cfg_t  mirror_cfg;
  logic [31:0] shadow_pix [MaxW*MaxH];
  bit          shadow_set [MaxW*MaxH];
  int          errors = 0;
  int          cycles = 0;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %08h want %08h", what, got, want);
    errors++;
  endtask

  function automatic int usable_w();
    return (mirror_cfg.dest_width < MaxW) ? int'(mirror_cfg.dest_width) : MaxW;
  endfunction

  function automatic int usable_h();
    return (mirror_cfg.dest_height < MaxH) ? int'(mirror_cfg.dest_height) : MaxH;
  endfunction

  function automatic bit in_frame(int x, int y);
    return x >= 0 && y >= 0 && x < usable_w() && y < usable_h();
  endfunction

  function automatic int target_x(cabfs_in_t w);
    return int'(w.pos_x) + ((w.func == FUNC_BLIT) ? int'($signed(mirror_cfg.x_offset)) : 0);
  endfunction

  function automatic int target_y(cabfs_in_t w);
    return int'(w.pos_y) + ((w.func == FUNC_BLIT) ? int'($signed(mirror_cfg.y_offset)) : 0);
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] dst, logic [31:0] src);
    int unsigned sa;
    int unsigned da;
    int unsigned d;
    int unsigned s;
    logic [31:0] r;
    sa = src[31:24];
    da = dst[31:24];
    r[31:24] = 8'(255 - ((255 - da) * (255 - sa)) / 255);
    for (int k = 0; k < 3; k++) begin
      d = dst[8*k +: 8];
      s = src[8*k +: 8];
      r[8*k +: 8] = 8'((d * (255 - sa) + s * sa) / 255);
    end
    return r;
  endfunction

  function automatic cabfs_out_t predict_result(cabfs_in_t w);
    cabfs_out_t r;
    int x;
    int y;
    int i;
    logic [7:0] sa;
    r  = '0;
    x  = target_x(w);
    y  = target_y(w);
    sa = w.pixel[31:24];
    if (w.func == FUNC_NOP) return r;
    if (!in_frame(x, y)) begin
      r.clipped = 1'b1;
      return r;
    end
    i = y * MaxW + x;
    case (w.func)
      FUNC_READ: r.read_value = shadow_pix[i];
      FUNC_WRITE: begin
        shadow_pix[i] = w.pixel;
        shadow_set[i] = 1'b1;
        r.changed     = 1'b1;
      end
      default: begin
        if (!mirror_cfg.blend_mode || sa == 8'hFF) begin
          shadow_pix[i] = w.pixel;
          shadow_set[i] = 1'b1;
          r.changed     = 1'b1;
        end else if (sa != 8'h00) begin
          shadow_pix[i] = blend_over(shadow_pix[i], w.pixel);
          r.changed     = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic cabfs_in_t pick_word();
    cabfs_in_t w;
    int tx;
    int ty;
    int px;
    int py;
    int ax;
    int ay;
    int roll;
    roll    = $urandom_range(99);
    w.func  = (roll < 30) ? FUNC_READ : (roll < 60) ? FUNC_WRITE :
              (roll < 95) ? FUNC_BLIT : FUNC_NOP;
    w.pixel = $urandom;
    case ($urandom_range(3))
      0: w.pixel[31:24] = 8'h00;
      1: w.pixel[31:24] = 8'hFF;
      default: ;
    endcase
    tx = $urandom_range(1) ? int'($urandom_range(7)) : int'($urandom_range(usable_w() + 1)) - 1;
    ty = $urandom_range(1) ? int'($urandom_range(7)) : int'($urandom_range(usable_h() + 1)) - 1;
    if (w.func == FUNC_BLIT) begin
      tx = tx - int'($signed(mirror_cfg.x_offset));
      ty = ty - int'($signed(mirror_cfg.y_offset));
    end
    px = (tx < 0 || tx > 4095 || $urandom_range(9) == 0) ? int'($urandom_range(4095)) : tx;
    py = (ty < 0 || ty > 4095 || $urandom_range(9) == 0) ? int'($urandom_range(4095)) : ty;
    w.pos_x = 12'(px);
    w.pos_y = 12'(py);
    ax = target_x(w);
    ay = target_y(w);
    // keep clear of entries never written
    if (in_frame(ax, ay) && !shadow_set[ay*MaxW + ax]) begin
      if (w.func == FUNC_READ) begin
        w.func = FUNC_WRITE;
      end else if (w.func == FUNC_BLIT && mirror_cfg.blend_mode &&
                   w.pixel[31:24] != 8'h00 && w.pixel[31:24] != 8'hFF) begin
        w.pixel[31:24] = 8'hFF;
      end
    end
    return w;
  endfunction

  task automatic send_word(cabfs_in_t w, bit typed, cabfs_out_t want);
    cabfs_out_t got;
    if (!no_gaps && $urandom_range(99) < 33) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    got = predict_result(w);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(cabfs_reg_e idx, logic [12:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DEST_WIDTH:  mirror_cfg.dest_width  = val[9:0];
      REG_DEST_HEIGHT: mirror_cfg.dest_height = val[9:0];
      REG_X_OFFSET:    mirror_cfg.x_offset    = val;
      REG_Y_OFFSET:    mirror_cfg.y_offset    = val;
      REG_BLEND_MODE:  mirror_cfg.blend_mode  = val[0];
      default: ;
    endcase
  endtask

  task automatic add_word(cabfs_func_e f, int x, int y, logic [31:0] pix, bit typed = 0,
                          logic [31:0] rd = '0, bit chg = 0, bit clp = 0);
    plan_row_t row;
    row.is_cfg          = 1'b0;
    row.reg_idx         = REG_DEST_WIDTH;
    row.reg_val         = '0;
    row.word.func       = f;
    row.word.pos_x      = 12'(x);
    row.word.pos_y      = 12'(y);
    row.word.pixel      = pix;
    row.typed           = typed;
    row.want.read_value = rd;
    row.want.changed    = chg;
    row.want.clipped    = clp;
    plan.push_back(row);
  endtask

  task automatic add_cfg(cabfs_reg_e idx, int val);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = 13'(val);
    row.word    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endtask

  task automatic build_plan();
    add_word(FUNC_WRITE, 0, 0, 32'hFFFFFFFF, 1, 32'h0, 1, 0);
    add_word(FUNC_READ, 0, 0, 32'h0, 1, 32'hFFFFFFFF, 0, 0);
    add_word(FUNC_WRITE, 511, 511, 32'h0, 1, 32'h0, 1, 0);
    add_word(FUNC_READ, 511, 511, 32'hFFFFFFFF, 1, 32'h0, 0, 0);
    add_word(FUNC_WRITE, 512, 0, 32'hDEADBEEF, 1, 32'h0, 0, 1);
    add_word(FUNC_READ, 0, 4095, 32'h0, 1, 32'h0, 0, 1);
    add_word(FUNC_WRITE, 4095, 4095, 32'hFFFFFFFF, 1, 32'h0, 0, 1);
    add_word(FUNC_BLIT, 1, 1, 32'h12345678, 1, 32'h0, 1, 0);
    add_word(FUNC_READ, 1, 1, 32'h0, 1, 32'h12345678, 0, 0);
    add_word(FUNC_NOP, 5, 5, 32'hFFFFFFFF, 1, 32'h0, 0, 0);
    add_word(FUNC_BLIT, 4095, 0, 32'hFFFFFFFF, 1, 32'h0, 0, 1);
    add_cfg(REG_BLEND_MODE, 1);
    add_word(FUNC_WRITE, 3, 0, 32'h80404040, 1, 32'h0, 1, 0);
    add_word(FUNC_BLIT, 3, 0, 32'h00FFFFFF, 1, 32'h0, 0, 0);
    add_word(FUNC_BLIT, 3, 0, 32'h80C0C0C0);
    add_word(FUNC_READ, 3, 0, 32'h0);
    add_word(FUNC_BLIT, 4, 0, 32'hFF010203, 1, 32'h0, 1, 0);
    add_word(FUNC_READ, 4, 0, 32'h0, 1, 32'hFF010203, 0, 0);
    add_cfg(REG_X_OFFSET, -4096);
    add_word(FUNC_BLIT, 4095, 0, 32'hFF000000, 1, 32'h0, 0, 1);
    add_cfg(REG_X_OFFSET, 4095);
    add_word(FUNC_BLIT, 0, 0, 32'hFF000000, 1, 32'h0, 0, 1);
    add_cfg(REG_X_OFFSET, -4095);
    add_cfg(REG_Y_OFFSET, -4096);
    add_word(FUNC_BLIT, 4095, 4095, 32'hFF00FF00, 1, 32'h0, 0, 1);
    add_cfg(REG_Y_OFFSET, -4095);
    add_word(FUNC_BLIT, 4095, 4095, 32'hFF00FF00, 1, 32'h0, 1, 0);
    add_word(FUNC_READ, 0, 0, 32'h0, 1, 32'hFF00FF00, 0, 0);
    add_cfg(REG_Y_OFFSET, 4095);
    add_word(FUNC_BLIT, 0, 0, 32'hFF00FF00, 1, 32'h0, 0, 1);
    add_cfg(REG_X_OFFSET, 0);
    add_cfg(REG_Y_OFFSET, 0);
    add_cfg(REG_DEST_WIDTH, 0);
    add_word(FUNC_WRITE, 0, 0, 32'h11111111, 1, 32'h0, 0, 1);
    add_cfg(REG_DEST_WIDTH, 1023);
    add_cfg(REG_DEST_HEIGHT, 0);
    add_word(FUNC_READ, 0, 0, 32'h0, 1, 32'h0, 0, 1);
    add_cfg(REG_DEST_HEIGHT, 1023);
    add_word(FUNC_WRITE, 511, 0, 32'h5A5A5A5A, 1, 32'h0, 1, 0);
    add_word(FUNC_WRITE, 512, 5, 32'h5A5A5A5A, 1, 32'h0, 0, 1);
  endtask

  function automatic int pick_size();
    case ($urandom_range(7))
      0: return 1;
      1: return 1023;
      2: return 512;
      3: return 0;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(5))
      0: return -4096;
      1: return 4095;
      default: return int'($urandom_range(16)) - 8;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cabfs_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", out_o.read_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_o.read_value !== want.read_value)
          flag_mismatch("read_value", out_o.read_value, want.read_value);
        if (out_o.changed !== want.changed)
          flag_mismatch("changed", 32'(out_o.changed), 32'(want.changed));
        if (out_o.clipped !== want.clipped)
          flag_mismatch("clipped", 32'(out_o.clipped), 32'(want.clipped));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    mirror_cfg  = '0;
    mirror_cfg.dest_width  = 10'd512;
    mirror_cfg.dest_height = 10'd512;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_plan();
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_DEST_WIDTH, 13'(pick_size()));
      write_reg(REG_DEST_HEIGHT, 13'(pick_size()));
      write_reg(REG_X_OFFSET, 13'(pick_offset()));
      write_reg(REG_Y_OFFSET, 13'(pick_offset()));
      write_reg(REG_BLEND_MODE, 13'($urandom_range(1)));
      no_gaps = (p == 2);
      repeat (85) send_word(pick_word(), 1'b0, '0);
    end
    settle();

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
